/* hdl/char_lcd_nibble_interface_core_assert.svh */
// Assertion macros shared by the character LCD interface modules.
// Depends on nothing; included by modules that carry checks.
`ifndef CHAR_LCD_NIBBLE_INTERFACE_CORE_ASSERT_SVH
`define CHAR_LCD_NIBBLE_INTERFACE_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define CLNIB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clnib check failed");

// Next-cycle implication, disabled during reset
`define CLNIB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clnib check failed");

`endif

/* hdl/clnib_pkg.sv */
// Package for the character LCD 4-bit interface: types, codes and constants.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package clnib_pkg;

    // Default parameter values
    localparam int WAIT_WIDTH_DEF        = 16;
    localparam int SECOND_ROW_OFFSET_DEF = 64;

    // Decoupling queue
    localparam int QUEUE_DEPTH = 2;

    // Configuration register indexes
    localparam logic [1:0] CFG_PULSE_HIGH = 2'd0;
    localparam logic [1:0] CFG_NIBBLE_GAP = 2'd1;
    localparam logic [1:0] CFG_POWERUP    = 2'd2;
    localparam logic [1:0] CFG_INIT_FINAL = 2'd3;

    localparam logic [7:0]  PULSE_HIGH_RST = 8'd1;
    localparam logic [9:0]  NIBBLE_GAP_RST = 10'd50;
    localparam logic [15:0] POWERUP_RST    = 16'd40000;
    localparam logic [15:0] INIT_FINAL_RST = 16'd10000;

    // Request modes
    localparam logic [2:0] MODE_INIT    = 3'd0;
    localparam logic [2:0] MODE_DATA    = 3'd1;
    localparam logic [2:0] MODE_COMMAND = 3'd2;
    localparam logic [2:0] MODE_CURSOR  = 3'd3;
    localparam logic [2:0] MODE_CLEAR   = 3'd4;

    // Init sequence steps (none = plain request in flight)
    localparam logic [3:0] STEP_NONE     = 4'd0;
    localparam logic [3:0] STEP_WAKE1    = 4'd1;
    localparam logic [3:0] STEP_WAKE2    = 4'd2;
    localparam logic [3:0] STEP_WAKE3    = 4'd3;
    localparam logic [3:0] STEP_FOUR_BIT = 4'd4;
    localparam logic [3:0] STEP_FUNC_SET = 4'd5;
    localparam logic [3:0] STEP_DISP_ON  = 4'd6;
    localparam logic [3:0] STEP_ENTRY    = 4'd7;
    localparam logic [3:0] STEP_CLEAR    = 4'd8;

    // Panel command bytes and nibbles
    localparam logic [7:0] CMD_FUNC_SET  = 8'h28;
    localparam logic [7:0] CMD_DISP_ON   = 8'h0C;
    localparam logic [7:0] CMD_ENTRY     = 8'h06;
    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [3:0] NIB_WAKE      = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT  = 4'h2;

    // Fixed init waits in ticks
    localparam logic [15:0] WAIT_5MS   = 16'd5000;
    localparam logic [15:0] WAIT_150US = 16'd150;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_PWRUP,
        PH_EHIGH,
        PH_GAP,
        PH_EXTRA
    } phase_t;

    typedef struct packed {
        logic [7:0]  pulse_high_ticks;
        logic [9:0]  nibble_gap_ticks;
        logic [15:0] powerup_ticks;
        logic [15:0] init_final_ticks;
    } cfg_t;

    // Classified item, front to back
    typedef struct packed {
        logic       tick;
        logic       take;
        logic       is_init;
        logic [7:0] send_byte;
        logic       select;
    } item_t;

    typedef struct packed {
        logic       enable;
        logic       select;
        logic [3:0] data;
        logic       ready;
        logic       accepted;
    } result_t;

    // Command byte sent by an init step that sends a full byte
    function automatic logic [7:0] init_cmd(input logic [3:0] step);
        logic [7:0] c;
        begin
            c = CMD_CLEAR;
            case (step)
                STEP_FUNC_SET: c = CMD_FUNC_SET;
                STEP_DISP_ON:  c = CMD_DISP_ON;
                STEP_ENTRY:    c = CMD_ENTRY;
                default:       c = CMD_CLEAR;
            endcase
            return c;
        end
    endfunction

endpackage

/* hdl/clnib_front.sv */
// Front end: decodes a request into a classified item for the back end.
// Depends on clnib_pkg.
`timescale 1ns / 1ps

module clnib_front #(
    parameter int SECOND_ROW_OFFSET = clnib_pkg::SECOND_ROW_OFFSET_DEF
) (
    input  logic                tick,
    input  logic                request,
    input  logic [2:0]          mode,
    input  logic [7:0]          byte_value,
    input  logic [5:0]          column,
    input  logic                row,
    output clnib_pkg::item_t    item
);

    logic [7:0] line_offset;
    logic [7:0] cursor_addr;

    // DDRAM address for set cursor, wrapped to 8 bits
    assign line_offset = row ? 8'(SECOND_ROW_OFFSET) : 8'd0;
    assign cursor_addr = {2'b00, column} + line_offset;

    // Mode decode
    always_comb
    begin
        item.tick      = tick;
        item.take      = request;
        item.is_init   = 1'b0;
        item.send_byte = byte_value;
        item.select    = 1'b0;
        unique case (mode)
            clnib_pkg::MODE_INIT:    item.is_init = 1'b1;
            clnib_pkg::MODE_DATA:    item.select = 1'b1;
            clnib_pkg::MODE_COMMAND: item.select = 1'b0;
            clnib_pkg::MODE_CURSOR:  item.send_byte = clnib_pkg::CMD_SET_DDRAM | cursor_addr;
            clnib_pkg::MODE_CLEAR:   item.send_byte = clnib_pkg::CMD_CLEAR;
            default:                 item.take = 1'b0;
        endcase
    end

endmodule

/* hdl/clnib_queue.sv */
// Short FIFO of classified items between the front and back ends.
// Depends on clnib_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "char_lcd_nibble_interface_core_assert.svh"

module clnib_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  clnib_pkg::item_t    push_item,
    output logic                pop_valid,
    input  logic                pop,
    output clnib_pkg::item_t    pop_item
);

    localparam int DEPTH = clnib_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    clnib_pkg::item_t mem [DEPTH];

    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop_item   = mem[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    `CLNIB_ASSERT_NOW(a_queue_no_underflow, clk, rst_n, pop, count_reg != '0)
    `CLNIB_ASSERT_NEXT(a_queue_count_track, clk, rst_n, push && !pop,
        count_reg == $past(count_reg) + CW'(1))

endmodule

/* hdl/clnib_back.sv */
// Back end: nibble sequencer, tick timer and result register.
// Depends on clnib_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "char_lcd_nibble_interface_core_assert.svh"

module clnib_back #(
    parameter int WAIT_WIDTH = clnib_pkg::WAIT_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  clnib_pkg::cfg_t     cfg,
    input  logic                item_valid,
    input  clnib_pkg::item_t    item,
    output logic                item_pop,
    output logic                out_valid,
    input  logic                out_ready,
    output clnib_pkg::result_t  result
);

    localparam logic [32:0] WAIT_MAX = (33'd1 << WAIT_WIDTH) - 33'd1;

    // Zero acts as one tick, long waits saturate at the counter's limit
    function automatic logic [WAIT_WIDTH-1:0] load_wait(input logic [15:0] v);
        logic [32:0] w;
        begin
            w = {17'd0, v};
            if (v == 16'd0)
            begin
                w = 33'd1;
            end
            if (w > WAIT_MAX)
            begin
                w = WAIT_MAX;
            end
            return w[WAIT_WIDTH-1:0];
        end
    endfunction

    clnib_pkg::phase_t     phase_reg, phase_next;
    logic [3:0]            step_reg, step_next;
    logic [WAIT_WIDTH-1:0] wait_reg, wait_next;
    logic [WAIT_WIDTH-1:0] wait_dec;
    logic [7:0]            held_reg, held_next;
    logic                  low_half_reg, low_half_next;
    logic                  select_reg, select_next;
    logic [3:0]            nibble_reg, nibble_next;
    logic                  enable_reg, enable_next;
    logic                  out_valid_reg;
    clnib_pkg::result_t    result_reg, result_next;
    logic                  acc;
    logic                  begin_en;
    logic [3:0]            begin_k;
    logic [7:0]            begin_byte;

    // Take the next queued item when the result register is free or being drained
    assign item_pop  = item_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result    = result_reg;
    assign wait_dec  = (wait_reg != '0) ? wait_reg - WAIT_WIDTH'(1) : wait_reg;

    // Next state
    always_comb
    begin
        phase_next    = phase_reg;
        step_next     = step_reg;
        wait_next     = wait_reg;
        held_next     = held_reg;
        low_half_next = low_half_reg;
        select_next   = select_reg;
        nibble_next   = nibble_reg;
        enable_next   = enable_reg;
        acc           = 1'b0;
        begin_en      = 1'b0;
        begin_k       = step_reg + 4'd1;
        begin_byte    = clnib_pkg::init_cmd(begin_k);
        if (item_pop)
        begin
            if (phase_reg == clnib_pkg::PH_IDLE)
            begin
                if (item.take)
                begin
                    acc       = 1'b1;
                    step_next = clnib_pkg::STEP_NONE;
                    if (item.is_init)
                    begin
                        select_next   = 1'b0;
                        enable_next   = 1'b0;
                        low_half_next = 1'b0;
                        phase_next    = clnib_pkg::PH_PWRUP;
                        wait_next     = load_wait(cfg.powerup_ticks);
                    end
                    else
                    begin
                        held_next     = item.send_byte;
                        select_next   = item.select;
                        low_half_next = 1'b1;
                        nibble_next   = item.send_byte[7:4];
                        enable_next   = 1'b1;
                        phase_next    = clnib_pkg::PH_EHIGH;
                        wait_next     = load_wait({8'd0, cfg.pulse_high_ticks});
                    end
                end
            end
            else if (item.tick)
            begin
                wait_next = wait_dec;
                if (wait_dec == '0)
                begin
                    unique case (phase_reg)
                        clnib_pkg::PH_PWRUP:
                        begin
                            begin_en = 1'b1;
                            begin_k  = clnib_pkg::STEP_WAKE1;
                        end
                        clnib_pkg::PH_EHIGH:
                        begin
                            enable_next = 1'b0;
                            phase_next  = clnib_pkg::PH_GAP;
                            wait_next   = load_wait({6'd0, cfg.nibble_gap_ticks});
                        end
                        clnib_pkg::PH_GAP:
                        begin
                            if (low_half_reg)
                            begin
                                low_half_next = 1'b0;
                                nibble_next   = held_reg[3:0];
                                enable_next   = 1'b1;
                                phase_next    = clnib_pkg::PH_EHIGH;
                                wait_next     = load_wait({8'd0, cfg.pulse_high_ticks});
                            end
                            else
                            begin
                                case (step_reg)
                                    clnib_pkg::STEP_NONE:
                                        phase_next = clnib_pkg::PH_IDLE;
                                    clnib_pkg::STEP_WAKE1:
                                    begin
                                        phase_next = clnib_pkg::PH_EXTRA;
                                        wait_next  = load_wait(clnib_pkg::WAIT_5MS);
                                    end
                                    clnib_pkg::STEP_WAKE2:
                                    begin
                                        phase_next = clnib_pkg::PH_EXTRA;
                                        wait_next  = load_wait(clnib_pkg::WAIT_150US);
                                    end
                                    clnib_pkg::STEP_CLEAR:
                                    begin
                                        phase_next = clnib_pkg::PH_EXTRA;
                                        wait_next  = load_wait(cfg.init_final_ticks);
                                    end
                                    default:
                                        begin_en = 1'b1;
                                endcase
                            end
                        end
                        clnib_pkg::PH_EXTRA:
                        begin
                            if (step_reg >= clnib_pkg::STEP_CLEAR)
                            begin
                                step_next  = clnib_pkg::STEP_NONE;
                                phase_next = clnib_pkg::PH_IDLE;
                            end
                            else
                            begin
                                begin_en = 1'b1;
                            end
                        end
                        default:
                            phase_next = clnib_pkg::PH_IDLE;
                    endcase
                end
            end
        end
        // Start the next init step
        if (begin_en)
        begin
            step_next = begin_k;
            case (begin_k) inside
                clnib_pkg::STEP_WAKE1, clnib_pkg::STEP_WAKE2, clnib_pkg::STEP_WAKE3:
                begin
                    nibble_next = clnib_pkg::NIB_WAKE;
                    enable_next = 1'b1;
                    phase_next  = clnib_pkg::PH_EHIGH;
                    wait_next   = load_wait({8'd0, cfg.pulse_high_ticks});
                end
                clnib_pkg::STEP_FOUR_BIT:
                begin
                    nibble_next = clnib_pkg::NIB_FOUR_BIT;
                    enable_next = 1'b1;
                    phase_next  = clnib_pkg::PH_EHIGH;
                    wait_next   = load_wait({8'd0, cfg.pulse_high_ticks});
                end
                clnib_pkg::STEP_FUNC_SET, clnib_pkg::STEP_DISP_ON,
                clnib_pkg::STEP_ENTRY, clnib_pkg::STEP_CLEAR:
                begin
                    held_next     = begin_byte;
                    select_next   = 1'b0;
                    low_half_next = 1'b1;
                    nibble_next   = begin_byte[7:4];
                    enable_next   = 1'b1;
                    phase_next    = clnib_pkg::PH_EHIGH;
                    wait_next     = load_wait({8'd0, cfg.pulse_high_ticks});
                end
                default:
                begin
                    step_next  = clnib_pkg::STEP_NONE;
                    phase_next = clnib_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Outputs: pin levels and status after this item
    always_comb
    begin
        result_next.enable   = enable_next;
        result_next.select   = select_next;
        result_next.data     = nibble_next;
        result_next.ready    = (phase_next == clnib_pkg::PH_IDLE);
        result_next.accepted = acc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= clnib_pkg::PH_IDLE;
            step_reg      <= clnib_pkg::STEP_NONE;
            wait_reg      <= '0;
            held_reg      <= '0;
            low_half_reg  <= 1'b0;
            select_reg    <= 1'b0;
            nibble_reg    <= '0;
            enable_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            step_reg      <= step_next;
            wait_reg      <= wait_next;
            held_reg      <= held_next;
            low_half_reg  <= low_half_next;
            select_reg    <= select_next;
            nibble_reg    <= nibble_next;
            enable_reg    <= enable_next;
            if (item_pop)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            result_reg <= result_next;
        end
    end

    `CLNIB_ASSERT_NOW(a_enable_only_in_pulse, clk, rst_n, enable_reg,
        phase_reg == clnib_pkg::PH_EHIGH)
    `CLNIB_ASSERT_NOW(a_step_in_range, clk, rst_n, 1'b1,
        step_reg <= clnib_pkg::STEP_CLEAR)
    `CLNIB_ASSERT_NEXT(a_timer_holds_without_tick, clk, rst_n,
        item_pop && !item.tick && phase_reg != clnib_pkg::PH_IDLE, $stable(wait_reg))

endmodule

/* hdl/char_lcd_nibble_interface_core.sv */
// Top level of the character LCD 4-bit interface: config registers, front,
// queue and back end. Depends on clnib_pkg, clnib_front, clnib_queue, clnib_back.
`timescale 1ns / 1ps
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  input    | in_valid/in_ready   | tick, request, mode, byte_value, column, row
//  output   | out_valid/out_ready | enable_pin, select_pin, data_pins, ready_res,
//           |                     | accepted
//  config   | cfg_write           | cfg_index, cfg_data
//
//  One item per cycle sustained while the output keeps draining; a transfer in
//  is written into the queue at its accepting edge, and the sequencer steps it
//  into the result register once that register is free or being drained.
//  The sequencer takes one queued item per cycle while the result register is
//  free or being drained; a two-entry queue absorbs a stalled output.
//  Reset empties the queue, puts the sequencer idle and loads register defaults;
//  the panel is not initialised until an init request is sent.

module char_lcd_nibble_interface_core #(
    parameter int WAIT_WIDTH        = clnib_pkg::WAIT_WIDTH_DEF,
    parameter int SECOND_ROW_OFFSET = clnib_pkg::SECOND_ROW_OFFSET_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        tick,
    input  logic        request,
    input  logic [2:0]  mode,
    input  logic [7:0]  byte_value,
    input  logic [5:0]  column,
    input  logic        row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        enable_pin,
    output logic        select_pin,
    output logic [3:0]  data_pins,
    output logic        ready_res,
    output logic        accepted,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    clnib_pkg::cfg_t    cfg_reg;
    clnib_pkg::item_t   front_item;
    clnib_pkg::item_t   queue_item;
    clnib_pkg::result_t result;
    logic               queue_valid;
    logic               queue_pop;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pulse_high_ticks <= clnib_pkg::PULSE_HIGH_RST;
            cfg_reg.nibble_gap_ticks <= clnib_pkg::NIBBLE_GAP_RST;
            cfg_reg.powerup_ticks    <= clnib_pkg::POWERUP_RST;
            cfg_reg.init_final_ticks <= clnib_pkg::INIT_FINAL_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                clnib_pkg::CFG_PULSE_HIGH: cfg_reg.pulse_high_ticks <= cfg_data[7:0];
                clnib_pkg::CFG_NIBBLE_GAP: cfg_reg.nibble_gap_ticks <= cfg_data[9:0];
                clnib_pkg::CFG_POWERUP:    cfg_reg.powerup_ticks    <= cfg_data;
                clnib_pkg::CFG_INIT_FINAL: cfg_reg.init_final_ticks <= cfg_data;
                default:                   cfg_reg.init_final_ticks <= cfg_reg.init_final_ticks;
            endcase
        end
    end

    clnib_front #(
        .SECOND_ROW_OFFSET (SECOND_ROW_OFFSET)
    ) u_front (
        .tick       (tick),
        .request    (request),
        .mode       (mode),
        .byte_value (byte_value),
        .column     (column),
        .row        (row),
        .item       (front_item)
    );

    clnib_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (in_valid),
        .push_ready (in_ready),
        .push_item  (front_item),
        .pop_valid  (queue_valid),
        .pop        (queue_pop),
        .pop_item   (queue_item)
    );

    clnib_back #(
        .WAIT_WIDTH (WAIT_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (queue_valid),
        .item       (queue_item),
        .item_pop   (queue_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result     (result)
    );

    assign enable_pin = result.enable;
    assign select_pin = result.select;
    assign data_pins  = result.data;
    assign ready_res  = result.ready;
    assign accepted   = result.accepted;

endmodule

/* test/tb_char_lcd_nibble_interface_core.sv */
// Testbench for char_lcd_nibble_interface_core: directed table, then random traffic,
// every result checked against its table entry or an in-bench model of the LCD sequencer.
// Depends on clnib_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_char_lcd_nibble_interface_core;

    localparam int          ROW2_OFFSET  = clnib_pkg::SECOND_ROW_OFFSET_DEF;
    localparam int unsigned WAIT_MAX     = (1 << clnib_pkg::WAIT_WIDTH_DEF) - 1;
    localparam int unsigned LONG_WAIT    = 40;
    localparam int          HOLD_CYCLES  = 300;
    localparam int          DRAIN_CYCLES = 6;
    localparam int          STALL_LIMIT  = 3000;
    localparam int          DIR_ROWS     = 16;
    // First table row run with the short timing
    localparam int          RETIME_ROW   = 5;
    // Items sent after the init request; the 5 ms wake wait outlasts them
    localparam int unsigned INIT_ITEMS   = 40;

    // Mode codes the block must ignore
    localparam logic [2:0] MODE_UNUSED_LO  = 3'd5;
    localparam logic [2:0] MODE_UNUSED_MID = 3'd6;
    localparam logic [2:0] MODE_UNUSED_HI  = 3'd7;

    localparam clnib_pkg::result_t NO_CHECK = '0;

    typedef struct {
        bit                 tick;
        bit                 request;
        logic [2:0]         mode;
        logic [7:0]         byte_value;
        logic [5:0]         column;
        bit                 row_sel;
        bit                 typed;
        clnib_pkg::result_t want;
        bit                 run_out;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        tick;
    logic        request;
    logic [2:0]  mode;
    logic [7:0]  byte_value;
    logic [5:0]  column;
    logic        row;
    logic        out_valid;
    logic        out_ready;
    logic        enable_pin;
    logic        select_pin;
    logic [3:0]  data_pins;
    logic        ready_res;
    logic        accepted;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    char_lcd_nibble_interface_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .tick       (tick),
        .request    (request),
        .mode       (mode),
        .byte_value (byte_value),
        .column     (column),
        .row        (row),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .enable_pin (enable_pin),
        .select_pin (select_pin),
        .data_pins  (data_pins),
        .ready_res  (ready_res),
        .accepted   (accepted),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Expected pin states, oldest first
    clnib_pkg::result_t want_pins_q[$];
    int                 mismatches = 0;
    bit                 burst      = 1'b0;
    bit                 rush       = 1'b0;
    bit                 hold_out   = 1'b0;
    stim_row_t          dir_tab [DIR_ROWS];

    // ------------------------------------------------------------------
    // Sequencer model: timing registers and countdown state
    // ------------------------------------------------------------------
    clnib_pkg::cfg_t   lcd_cfg;
    clnib_pkg::phase_t lcd_phase;
    logic [3:0]        lcd_init_step;
    int unsigned       lcd_wait;
    logic [7:0]        lcd_held;
    bit                lcd_low_next;
    bit                lcd_rs;
    logic [3:0]        lcd_nib;
    bit                lcd_e;

    function automatic void lcd_reset();
        lcd_cfg.pulse_high_ticks = clnib_pkg::PULSE_HIGH_RST;
        lcd_cfg.nibble_gap_ticks = clnib_pkg::NIBBLE_GAP_RST;
        lcd_cfg.powerup_ticks    = clnib_pkg::POWERUP_RST;
        lcd_cfg.init_final_ticks = clnib_pkg::INIT_FINAL_RST;
        lcd_phase     = clnib_pkg::PH_IDLE;
        lcd_init_step = clnib_pkg::STEP_NONE;
        lcd_wait      = 0;
        lcd_held      = '0;
        lcd_low_next  = 1'b0;
        lcd_rs        = 1'b0;
        lcd_nib       = '0;
        lcd_e         = 1'b0;
    endfunction

    // Zero counts as one tick; anything past the counter width saturates
    function automatic void lcd_load_wait(input int unsigned v);
        lcd_wait = (v == 0) ? 1 : ((v > WAIT_MAX) ? WAIT_MAX : v);
    endfunction

    function automatic void lcd_start_nibble(input logic [3:0] nib);
        lcd_nib   = nib;
        lcd_e     = 1'b1;
        lcd_phase = clnib_pkg::PH_EHIGH;
        lcd_load_wait(lcd_cfg.pulse_high_ticks);
    endfunction

    function automatic void lcd_start_byte(input logic [7:0] b, input bit rs);
        lcd_held     = b;
        lcd_rs       = rs;
        lcd_low_next = 1'b1;
        lcd_start_nibble(b[7:4]);
    endfunction

    function automatic void lcd_begin_step(input logic [3:0] k);
        lcd_init_step = k;
        case (k)
            clnib_pkg::STEP_WAKE1, clnib_pkg::STEP_WAKE2, clnib_pkg::STEP_WAKE3:
                lcd_start_nibble(clnib_pkg::NIB_WAKE);
            clnib_pkg::STEP_FOUR_BIT: lcd_start_nibble(clnib_pkg::NIB_FOUR_BIT);
            clnib_pkg::STEP_FUNC_SET: lcd_start_byte(clnib_pkg::CMD_FUNC_SET, 1'b0);
            clnib_pkg::STEP_DISP_ON:  lcd_start_byte(clnib_pkg::CMD_DISP_ON, 1'b0);
            clnib_pkg::STEP_ENTRY:    lcd_start_byte(clnib_pkg::CMD_ENTRY, 1'b0);
            clnib_pkg::STEP_CLEAR:    lcd_start_byte(clnib_pkg::CMD_CLEAR, 1'b0);
            default:
            begin
                lcd_init_step = clnib_pkg::STEP_NONE;
                lcd_phase     = clnib_pkg::PH_IDLE;
            end
        endcase
    endfunction

    // Every nibble of the current item is out
    function automatic void lcd_item_sent();
        case (lcd_init_step)
            clnib_pkg::STEP_NONE: lcd_phase = clnib_pkg::PH_IDLE;
            clnib_pkg::STEP_WAKE1:
            begin
                lcd_phase = clnib_pkg::PH_EXTRA;
                lcd_load_wait(clnib_pkg::WAIT_5MS);
            end
            clnib_pkg::STEP_WAKE2:
            begin
                lcd_phase = clnib_pkg::PH_EXTRA;
                lcd_load_wait(clnib_pkg::WAIT_150US);
            end
            clnib_pkg::STEP_CLEAR:
            begin
                lcd_phase = clnib_pkg::PH_EXTRA;
                lcd_load_wait(lcd_cfg.init_final_ticks);
            end
            default: lcd_begin_step(lcd_init_step + 4'd1);
        endcase
    endfunction

    function automatic void lcd_countdown_done();
        case (lcd_phase)
            clnib_pkg::PH_PWRUP: lcd_begin_step(clnib_pkg::STEP_WAKE1);
            clnib_pkg::PH_EHIGH:
            begin
                lcd_e     = 1'b0;
                lcd_phase = clnib_pkg::PH_GAP;
                lcd_load_wait(lcd_cfg.nibble_gap_ticks);
            end
            clnib_pkg::PH_GAP:
            begin
                if (lcd_low_next)
                begin
                    lcd_low_next = 1'b0;
                    lcd_start_nibble(lcd_held[3:0]);
                end
                else
                    lcd_item_sent();
            end
            clnib_pkg::PH_EXTRA:
            begin
                if (lcd_init_step >= clnib_pkg::STEP_CLEAR)
                begin
                    lcd_init_step = clnib_pkg::STEP_NONE;
                    lcd_phase     = clnib_pkg::PH_IDLE;
                end
                else
                    lcd_begin_step(lcd_init_step + 4'd1);
            end
            default: lcd_phase = clnib_pkg::PH_IDLE;
        endcase
    endfunction

    // One input transfer in, the pin state after it out
    function automatic clnib_pkg::result_t lcd_predict(input bit t, input bit rq,
            input logic [2:0] md, input logic [7:0] bv, input logic [5:0] col,
            input bit rw);
        logic [7:0]         addr;
        bit                 acc;
        clnib_pkg::result_t r;
        acc = 1'b0;
        if (lcd_phase == clnib_pkg::PH_IDLE)
        begin
            if (rq && md <= clnib_pkg::MODE_CLEAR)
            begin
                acc           = 1'b1;
                lcd_init_step = clnib_pkg::STEP_NONE;
                case (md)
                    clnib_pkg::MODE_INIT:
                    begin
                        lcd_rs       = 1'b0;
                        lcd_e        = 1'b0;
                        lcd_low_next = 1'b0;
                        lcd_phase    = clnib_pkg::PH_PWRUP;
                        lcd_load_wait(lcd_cfg.powerup_ticks);
                    end
                    clnib_pkg::MODE_DATA:    lcd_start_byte(bv, 1'b1);
                    clnib_pkg::MODE_COMMAND: lcd_start_byte(bv, 1'b0);
                    clnib_pkg::MODE_CURSOR:
                    begin
                        addr = {2'b00, col} + (rw ? 8'(ROW2_OFFSET) : 8'd0);
                        lcd_start_byte(clnib_pkg::CMD_SET_DDRAM | addr, 1'b0);
                    end
                    default: lcd_start_byte(clnib_pkg::CMD_CLEAR, 1'b0);
                endcase
            end
        end
        else if (t)
        begin
            if (lcd_wait > 0)
                lcd_wait--;
            if (lcd_wait == 0)
                lcd_countdown_done();
        end
        r.enable   = lcd_e;
        r.select   = lcd_rs;
        r.data     = lcd_nib;
        r.ready    = (lcd_phase == clnib_pkg::PH_IDLE);
        r.accepted = acc;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_item(input bit t, input bit rq, input logic [2:0] md,
            input logic [7:0] bv, input logic [5:0] col, input bit rw,
            input bit typed, input clnib_pkg::result_t want,
            output clnib_pkg::result_t pred);
        int unsigned gap;
        // no idling in a burst or while a long countdown is running
        rush = burst || (lcd_phase != clnib_pkg::PH_IDLE && lcd_wait > LONG_WAIT);
        gap  = rush ? 0 : $urandom_range(0, 19);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        tick       <= t;
        request    <= rq;
        mode       <= md;
        byte_value <= bv;
        column     <= col;
        row        <= rw;
        do
            @(posedge clk);
        while (!in_ready);
        pred = lcd_predict(t, rq, md, bv, col, rw);
        want_pins_q.push_back(typed ? want : pred);
    endtask

    // Mostly ticks while busy, with stray requests mixed in
    task automatic send_busy_item(output bit ticked);
        clnib_pkg::result_t pred;
        bit                 t;
        t = (lcd_wait > LONG_WAIT) ? 1'b1 : ($urandom_range(0, 7) != 0);
        send_item(t, 1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                  8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                  1'($urandom_range(0, 1)), 1'b0, NO_CHECK, pred);
        ticked = t;
    endtask

    task automatic run_to_idle();
        bit ticked;
        while (lcd_phase != clnib_pkg::PH_IDLE)
            send_busy_item(ticked);
    endtask

    // Init request, then a fixed number of items into the power-up sequence
    task automatic send_init(input int unsigned n);
        clnib_pkg::result_t pred;
        bit                 ticked;
        send_item(1'($urandom_range(0, 1)), 1'b1, clnib_pkg::MODE_INIT,
                  8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                  1'($urandom_range(0, 1)), 1'b0, NO_CHECK, pred);
        repeat (n)
            send_busy_item(ticked);
    endtask

    // Random requests with their tick streams; target counts transfers that move the block
    task automatic random_traffic(input int unsigned target);
        int unsigned        advanced;
        int unsigned        pick;
        clnib_pkg::result_t pred;
        bit                 ticked;
        logic [2:0]         md;
        advanced = 0;
        while (advanced < target)
        begin
            if ($urandom_range(0, 39) == 0)
                burst = ~burst;
            if (lcd_phase == clnib_pkg::PH_IDLE)
            begin
                pick = $urandom_range(0, 19);
                if (pick < 16)
                    md = 3'($urandom_range(clnib_pkg::MODE_DATA, clnib_pkg::MODE_CLEAR));
                else
                    md = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
                send_item(1'($urandom_range(0, 1)), pick < 18, md,
                          8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                          1'($urandom_range(0, 1)), 1'b0, NO_CHECK, pred);
                if (pred.accepted)
                    advanced++;
            end
            else
            begin
                send_busy_item(ticked);
                if (ticked)
                    advanced++;
            end
        end
        burst = 1'b0;
    endtask

    // Let every expected result come back before touching the registers
    task automatic quiesce();
        in_valid <= 1'b0;
        while (want_pins_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic program_timing(input logic [15:0] pulse, input logic [15:0] gap,
            input logic [15:0] pwr, input logic [15:0] fin);
        cfg_write <= 1'b1;
        cfg_index <= clnib_pkg::CFG_PULSE_HIGH;
        cfg_data  <= pulse;
        @(posedge clk);
        cfg_index <= clnib_pkg::CFG_NIBBLE_GAP;
        cfg_data  <= gap;
        @(posedge clk);
        cfg_index <= clnib_pkg::CFG_POWERUP;
        cfg_data  <= pwr;
        @(posedge clk);
        cfg_index <= clnib_pkg::CFG_INIT_FINAL;
        cfg_data  <= fin;
        @(posedge clk);
        cfg_write <= 1'b0;
        lcd_cfg.pulse_high_ticks = pulse[7:0];
        lcd_cfg.nibble_gap_ticks = gap[9:0];
        lcd_cfg.powerup_ticks    = pwr;
        lcd_cfg.init_final_ticks = fin;
    endtask

    // ------------------------------------------------------------------
    // Output side: random stalls plus one long hold-off
    // ------------------------------------------------------------------
    initial
    begin
        int gap;
        out_ready <= 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (hold_out)
            begin
                hold_out = 1'b0;
                gap      = HOLD_CYCLES;
            end
            else
                gap = rush ? 0 : $urandom_range(0, 19);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < 100)
            $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $time);
        mismatches++;
    endtask

    task automatic check_pin(input string what, input int got, input int want);
        if (got != want)
            report_mismatch(what, got, want);
    endtask

    // Compare each output transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        clnib_pkg::result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (want_pins_q.size() == 0)
                report_mismatch("result with nothing pending", 0, 0);
            else
            begin
                want = want_pins_q.pop_front();
                check_pin("enable_pin", enable_pin, want.enable);
                check_pin("select_pin", select_pin, want.select);
                check_pin("data_pins", data_pins, want.data);
                check_pin("ready_res", ready_res, want.ready);
                check_pin("accepted", accepted, want.accepted);
            end
        end
    end

    // Watchdog: too long with no transfer on either side
    always @(posedge clk)
    begin : stall_watch
        int quiet_cycles;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        clnib_pkg::result_t pred;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        tick       <= 1'b0;
        request    <= 1'b0;
        mode       <= clnib_pkg::MODE_INIT;
        byte_value <= '0;
        column     <= '0;
        row        <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_index  <= clnib_pkg::CFG_PULSE_HIGH;
        cfg_data   <= '0;
        lcd_reset();

        // tick, request, mode, byte, column, row, typed, expected, run to idle
        dir_tab = '{
            // idle, nothing requested
            '{1'b1, 1'b0, clnib_pkg::MODE_INIT, 8'h00, 6'd0, 1'b0, 1'b1,
              '{1'b0, 1'b0, 4'h0, 1'b1, 1'b0}, 1'b0},
            // unknown mode is dropped
            '{1'b0, 1'b1, MODE_UNUSED_HI, 8'hFF, 6'd63, 1'b1, 1'b1,
              '{1'b0, 1'b0, 4'h0, 1'b1, 1'b0}, 1'b0},
            // data 0xFF, tick on the accepting item is not counted
            '{1'b1, 1'b1, clnib_pkg::MODE_DATA, 8'hFF, 6'd0, 1'b0, 1'b1,
              '{1'b1, 1'b1, 4'hF, 1'b0, 1'b1}, 1'b0},
            // request while busy is ignored
            '{1'b0, 1'b1, clnib_pkg::MODE_COMMAND, 8'h00, 6'd0, 1'b0, 1'b1,
              '{1'b1, 1'b1, 4'hF, 1'b0, 1'b0}, 1'b0},
            // one-tick pulse ends, E drops
            '{1'b1, 1'b0, clnib_pkg::MODE_INIT, 8'h00, 6'd0, 1'b0, 1'b1,
              '{1'b0, 1'b1, 4'hF, 1'b0, 1'b0}, 1'b1},
            '{1'b0, 1'b1, clnib_pkg::MODE_COMMAND, 8'h00, 6'd0, 1'b0, 1'b1,
              '{1'b1, 1'b0, 4'h0, 1'b0, 1'b1}, 1'b1},
            // cursor at last column of the second row
            '{1'b1, 1'b1, clnib_pkg::MODE_CURSOR, 8'h00, 6'd63, 1'b1, 1'b1,
              '{1'b1, 1'b0, 4'hF, 1'b0, 1'b1}, 1'b1},
            '{1'b0, 1'b1, clnib_pkg::MODE_CURSOR, 8'hFF, 6'd0, 1'b0, 1'b1,
              '{1'b1, 1'b0, 4'h8, 1'b0, 1'b1}, 1'b1},
            '{1'b1, 1'b1, clnib_pkg::MODE_CURSOR, 8'h3C, 6'd37, 1'b1, 1'b0, NO_CHECK, 1'b1},
            // clear sends 0x01
            '{1'b1, 1'b1, clnib_pkg::MODE_CLEAR, 8'hFF, 6'd63, 1'b1, 1'b1,
              '{1'b1, 1'b0, 4'h0, 1'b0, 1'b1}, 1'b1},
            '{1'b0, 1'b1, clnib_pkg::MODE_DATA, 8'h00, 6'd21, 1'b0, 1'b1,
              '{1'b1, 1'b1, 4'h0, 1'b0, 1'b1}, 1'b1},
            '{1'b1, 1'b1, clnib_pkg::MODE_COMMAND, 8'hA5, 6'd42, 1'b1, 1'b0, NO_CHECK, 1'b1},
            '{1'b1, 1'b1, MODE_UNUSED_LO, 8'h5A, 6'd0, 1'b0, 1'b0, NO_CHECK, 1'b0},
            '{1'b1, 1'b0, MODE_UNUSED_MID, 8'hFF, 6'd63, 1'b1, 1'b0, NO_CHECK, 1'b0},
            '{1'b0, 1'b1, clnib_pkg::MODE_DATA, 8'h5A, 6'd0, 1'b0, 1'b0, NO_CHECK, 1'b1},
            '{1'b1, 1'b1, MODE_UNUSED_HI, 8'hFF, 6'd63, 1'b1, 1'b0, NO_CHECK, 1'b0}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: reset timing for the first byte, short timing after
        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (i == RETIME_ROW)
            begin
                quiesce();
                program_timing(16'd1, 16'd2, 16'd2, 16'd2);
            end
            send_item(dir_tab[i].tick, dir_tab[i].request, dir_tab[i].mode,
                      dir_tab[i].byte_value, dir_tab[i].column, dir_tab[i].row_sel,
                      dir_tab[i].typed, dir_tab[i].want, pred);
            if (dir_tab[i].run_out)
                run_to_idle();
        end
        quiesce();

        // Shortest legal timing
        program_timing(16'd1, 16'd1, 16'd1, 16'd1);
        random_traffic(100);
        run_to_idle();
        quiesce();

        // Upper bits of a register write are dropped
        program_timing(16'hFF06, 16'hFC0A, 16'hFFFF, 16'hFFFF);
        random_traffic(80);
        run_to_idle();
        quiesce();

        // Short timing with the output held off to back up the input
        program_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 12)),
                       16'($urandom_range(1, 300)), 16'($urandom_range(1, 300)));
        burst    = 1'b1;
        hold_out = 1'b1;
        random_traffic(150);
        run_to_idle();
        quiesce();

        program_timing(16'($urandom_range(2, 10)), 16'($urandom_range(1, 10)),
                       16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
        random_traffic(100);
        run_to_idle();
        quiesce();

        // Registers at zero act as one tick; init runs into the 5 ms wake wait
        program_timing(16'd0, 16'd0, 16'd0, 16'd0);
        random_traffic(60);
        run_to_idle();
        send_init(INIT_ITEMS);
        quiesce();

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
